FILE: src/swq_pkg.sv
// Shared types and constants for the slot allocator with wait queue.
// No dependencies; every other file of the block imports this package.
package swq_pkg;

  localparam int KEY_W           = 16;
  localparam int STATUS_W        = 3;
  localparam int SLOT_OUT_W      = 4;
  localparam int ACTIVE_W        = 5;
  localparam int DEF_SLOT_COUNT  = 16;
  localparam int DEF_QUEUE_DEPTH = 16;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED    = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_REFILLED  = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef struct packed {
    logic key_wr;
    logic valid_set;
    logic valid_clr;
  } slot_cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

FILE: src/slot_allocator_with_wait_queue_core.sv
// A request's result reaches out_valid after the slot scan, which checks one slot a cycle,
// and the S_DONE state, which loads the output register once it is free.
// One request at a time: in_ready is high only in the idle state.
// A result waiting in the output register does not block the next input transfer.
// Reset (synchronous, active low) clears slot valid flags, queue pointers and sets active_slots to 16.
// Depends on swq_pkg, swq_slot_store and swq_wait_fifo.
module slot_allocator_with_wait_queue_core #(
  parameter int SLOT_COUNT  = swq_pkg::DEF_SLOT_COUNT,
  parameter int QUEUE_DEPTH = swq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [swq_pkg::KEY_W-1:0]    in_key,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swq_pkg::STATUS_W-1:0] out_status,
  output logic [swq_pkg::SLOT_OUT_W-1:0] out_slot_index,
  output logic [swq_pkg::KEY_W-1:0]    out_moved_key,
  input  logic                         cfg_we,
  input  logic [swq_pkg::ACTIVE_W-1:0] cfg_wdata
);
  import swq_pkg::*;

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SCAN_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ALLOC = 4'b0010,
    S_FREE  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  cmd_r, cmd_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [SCAN_W-1:0]     lim_r, lim_nxt;
  logic [SCAN_W-1:0]     idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [IDX_W-1:0]      pend_idx_r, pend_idx_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [SLOT_OUT_W-1:0] res_slot_r, res_slot_nxt;
  logic [KEY_W-1:0]      res_moved_r, res_moved_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [KEY_W-1:0]      out_moved_r, out_moved_nxt;
  logic [ACTIVE_W-1:0]   active_r, active_nxt;

  logic [SCAN_W-1:0]     lim_cfg;
  logic [IDX_W-1:0]      idx_at;
  logic                  hit;
  slot_cmd_t             slot_cmd;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_W-1:0]      wr_key;
  logic [KEY_W-1:0]      rd_key;
  logic [SLOT_COUNT-1:0] slot_valid;
  fifo_cmd_t             fifo_cmd;
  logic [KEY_W-1:0]      head_key;
  fifo_stat_t            fifo_stat;

  swq_slot_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_slot_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_cmd   (slot_cmd),
    .wr_addr    (wr_addr),
    .wr_key     (wr_key),
    .rd_addr    (idx_at),
    .rd_key     (rd_key),
    .slot_valid (slot_valid)
  );

  swq_wait_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_wait_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_cmd  (fifo_cmd),
    .push_key  (key_r),
    .head_key  (head_key),
    .fifo_stat (fifo_stat)
  );

  assign lim_cfg = (32'(active_r) > SLOT_COUNT) ? SCAN_W'(SLOT_COUNT) : SCAN_W'(active_r);
  assign idx_at  = idx_r[IDX_W-1:0];
  assign hit     = pend_r && slot_valid[pend_idx_r] && (rd_key == key_r);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    lim_nxt        = lim_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_moved_nxt  = res_moved_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_moved_nxt  = out_moved_r;
    active_nxt     = cfg_we ? cfg_wdata : active_r;
    slot_cmd       = '0;
    fifo_cmd       = '0;
    wr_addr        = idx_at;
    wr_key         = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          key_nxt   = in_key;
          lim_nxt   = lim_cfg;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = (in_cmd == CMD_RELEASE) ? S_FREE : S_ALLOC;
        end
      end
      S_ALLOC: begin
        res_slot_nxt  = '0;
        res_moved_nxt = '0;
        if (idx_r < lim_r) begin
          if (!slot_valid[idx_at]) begin
            slot_cmd.key_wr    = 1'b1;
            slot_cmd.valid_set = 1'b1;
            res_status_nxt     = ST_PLACED;
            res_slot_nxt       = SLOT_OUT_W'(idx_at);
            state_nxt          = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          if (fifo_stat.full) begin
            res_status_nxt = ST_DROPPED;
          end else begin
            fifo_cmd.push  = 1'b1;
            res_status_nxt = ST_QUEUED;
          end
          state_nxt = S_DONE;
        end
      end
      S_FREE: begin
        if (hit) begin
          wr_addr      = pend_idx_r;
          res_slot_nxt = SLOT_OUT_W'(pend_idx_r);
          if (!fifo_stat.empty) begin
            slot_cmd.key_wr = 1'b1;
            wr_key          = head_key;
            fifo_cmd.pop    = 1'b1;
            res_status_nxt  = ST_REFILLED;
            res_moved_nxt   = head_key;
          end else begin
            slot_cmd.valid_clr = 1'b1;
            res_status_nxt     = ST_RELEASED;
            res_moved_nxt      = '0;
          end
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (!pend_r && (idx_r == lim_r)) begin
          res_status_nxt = ST_NOT_FOUND;
          res_slot_nxt   = '0;
          res_moved_nxt  = '0;
          state_nxt      = S_DONE;
        end else begin
          pend_nxt     = (idx_r < lim_r);
          pend_idx_nxt = idx_at;
          if (idx_r < lim_r) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_moved_nxt  = res_moved_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= ACTIVE_RESET;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    lim_r        <= lim_nxt;
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_moved_r  <= res_moved_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_moved_r  <= out_moved_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_moved_key  = out_moved_r;

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> out_valid_r)
    else $error("Finished result was not loaded into a free output register.");

  a_cmd_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREE) |-> (cmd_r == CMD_RELEASE))
    else $error("Release scan running for an allocate request.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC || state_r == S_FREE) |-> (idx_r <= lim_r))
    else $error("Slot scan index ran past the active range.");

endmodule

FILE: src/swq_slot_store.sv
// Slot key memory with registered read port and per-slot valid flags.
// Depends on swq_pkg for the key width and the slot command struct.
module swq_slot_store #(
  parameter int SLOT_COUNT = swq_pkg::DEF_SLOT_COUNT,
  parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  swq_pkg::slot_cmd_t       slot_cmd,
  input  logic [IDX_W-1:0]         wr_addr,
  input  logic [swq_pkg::KEY_W-1:0] wr_key,
  input  logic [IDX_W-1:0]         rd_addr,
  output logic [swq_pkg::KEY_W-1:0] rd_key,
  output logic [SLOT_COUNT-1:0]    slot_valid
);
  import swq_pkg::*;

  logic [KEY_W-1:0]      key_mem [SLOT_COUNT];
  logic [KEY_W-1:0]      rd_key_r;
  logic [SLOT_COUNT-1:0] valid_r;
  logic [SLOT_COUNT-1:0] valid_nxt;

  always_ff @(posedge clk) begin
    if (slot_cmd.key_wr) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key_r <= key_mem[rd_addr];
  end

  always_comb begin
    valid_nxt = valid_r;
    if (slot_cmd.valid_set) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    if (slot_cmd.valid_clr) begin
      valid_nxt[wr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign rd_key     = rd_key_r;
  assign slot_valid = valid_r;

  a_no_set_and_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(slot_cmd.valid_set && slot_cmd.valid_clr))
    else $error("Slot valid flag set and cleared in the same cycle.");

endmodule

FILE: src/swq_wait_fifo.sv
// Bounded FIFO of waiting keys with a registered head read.
// Depends on swq_pkg for the key width and the FIFO command and status structs.
module swq_wait_fifo #(
  parameter int QUEUE_DEPTH = swq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  swq_pkg::fifo_cmd_t        fifo_cmd,
  input  logic [swq_pkg::KEY_W-1:0] push_key,
  output logic [swq_pkg::KEY_W-1:0] head_key,
  output swq_pkg::fifo_stat_t       fifo_stat
);
  import swq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [KEY_W-1:0] key_mem [QUEUE_DEPTH];
  logic [KEY_W-1:0] head_key_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (fifo_cmd.push) begin
      key_mem[tail_r] <= push_key;
    end
    head_key_r <= key_mem[head_r];
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (fifo_cmd.push) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (fifo_cmd.pop) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign head_key        = head_key_r;
  assign fifo_stat.empty = (count_r == '0);
  assign fifo_stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cmd.pop |-> !fifo_stat.empty)
    else $error("Wait queue popped while empty.");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cmd.push |-> !fifo_stat.full)
    else $error("Wait queue pushed while full.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("Wait queue count exceeds its depth.");

endmodule
